@@ design/ssib_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and helpers of the spaced-seed index builder
// no dependencies
package ssib_pkg;

   localparam int MAX_SEED_LEN     = 6;
   localparam int MAX_STRIDE_DEF   = 8;
   localparam int MAX_LINE_LEN_DEF = 65536;
   localparam int BUCKET_SLOTS     = 8;
   localparam int QUEUE_DEPTH      = 2;

   localparam int IDX_W        = 2 * MAX_SEED_LEN;
   localparam int NUM_BUCKETS  = 1 << IDX_W;
   localparam int SLOT_W       = 3;
   localparam int SLOT_ADDR_W  = $clog2(BUCKET_SLOTS);
   localparam int CNT_W        = 4;
   localparam int START_W      = 16;
   localparam int TOTAL_W      = 32;
   localparam int SEED_LEN_W   = 3;
   localparam int STRIDE_REG_W = 4;
   localparam int CAP_W        = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [SEED_LEN_W-1:0]   SEED_LEN_RESET = 3'd6;
   localparam logic [STRIDE_REG_W-1:0] STRIDE_RESET   = 4'd6;
   localparam logic [CAP_W-1:0]        CAP_RESET      = 4'd8;

   // register indexes
   localparam logic [1:0] REG_SEED_LENGTH     = 2'd0;
   localparam logic [1:0] REG_STRIDE          = 2'd1;
   localparam logic [1:0] REG_BUCKET_CAPACITY = 2'd2;

   // transaction modes
   localparam logic [1:0] MODE_BASE = 2'd0;
   localparam logic [1:0] MODE_EOL  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   typedef enum logic [2:0] {
      ST_NO_SEED   = 3'd0,
      ST_STORED    = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_BAD_CHAR  = 3'd3,
      ST_LINE_LONG = 3'd4,
      ST_READ      = 3'd5,
      ST_HALTED    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OP_PLAIN = 2'd0,
      OP_SEED  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_IDLE  = 2'd1,
      BK_EXEC  = 2'd2,
      BK_RESP  = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [7:0]        base_char;
      logic [IDX_W-1:0]  bucket;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [IDX_W-1:0]   seed_index;
      logic [START_W-1:0] seed_start;
      logic [CNT_W-1:0]   entry_count;
      logic [START_W-1:0] read_position;
      logic [TOTAL_W-1:0] total_stored;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      status_type         status;
      logic [IDX_W-1:0]   seed_index;
      logic [START_W-1:0] seed_start;
      logic [SLOT_W-1:0]  slot;
   } cmd_type;

   // valid bit on top, 2-bit base code below
   function automatic logic [2:0] base_decode(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         CHAR_A: r = 3'b100;
         CHAR_C: r = 3'b101;
         CHAR_G: r = 3'b110;
         CHAR_T: r = 3'b111;
         default: r = 3'b000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/ssib_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// front end: accepts transactions, keeps the base window, line offset and halt flag
// and turns each transaction into a command; depends on ssib_pkg
module ssib_front import ssib_pkg::*; #(
   parameter int MAX_STRIDE   = MAX_STRIDE_DEF,
   parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire req_type                            req_payload,
   input  wire logic [SEED_LEN_W-1:0]              seed_len,
   input  wire logic [$clog2(MAX_STRIDE+1)-1:0]    stride,
   input  wire logic                               q_full,
   input  wire logic                               clearing,
   output logic                                    q_push,
   output cmd_type                                 q_cmd
);

   localparam int WIN_DEPTH = (MAX_SEED_LEN - 1) * MAX_STRIDE + 1;
   localparam int SPAN_W    = $clog2(WIN_DEPTH + 1);
   localparam int AGE_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int LINE_W    = $clog2(MAX_LINE_LEN) + 1;

   logic [1:0]        win_ff [WIN_DEPTH];
   logic [1:0]        win_in [WIN_DEPTH];
   logic [LINE_W-1:0] line_off_ff, line_off_in;
   logic              halted_ff, halted_in;
   logic              shift;
   logic              accept;
   logic [2:0]        decoded;
   logic [SPAN_W-1:0] span;
   logic [IDX_W-1:0]  seed_idx;
   logic [LINE_W-1:0] start;

   assign req_ready = !q_full && !clearing;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;
   assign decoded   = base_decode(req_payload.base_char);
   assign span      = SPAN_W'(seed_len - 3'd1) * SPAN_W'(stride);
   assign start     = line_off_ff - LINE_W'(span);

   always_comb begin
      win_in[0] = decoded[1:0];
      for (int i = 1; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   // tap j sits j strides back; first base most significant
   always_comb begin
      logic [AGE_W-1:0] age;
      seed_idx = '0;
      for (int j = 0; j < MAX_SEED_LEN; j++) begin
         age = AGE_W'(j * stride);
         if (j < int'(seed_len)) begin
            seed_idx[2*j +: 2] = win_in[age];
         end
      end
   end

   always_comb begin
      q_cmd            = '0;
      q_cmd.op         = OP_PLAIN;
      q_cmd.status     = ST_NO_SEED;
      line_off_in      = line_off_ff;
      halted_in        = halted_ff;
      shift            = 1'b0;
      if (halted_ff) begin
         q_cmd.status = ST_HALTED;
      end else begin
         case (req_payload.mode)
            MODE_BASE: begin
               if (!decoded[2]) begin
                  q_cmd.status = ST_BAD_CHAR;
                  halted_in    = 1'b1;
               end else if (line_off_ff >= LINE_W'(MAX_LINE_LEN)) begin
                  q_cmd.status = ST_LINE_LONG;
               end else begin
                  shift       = 1'b1;
                  line_off_in = line_off_ff + 1'b1;
                  if (line_off_ff >= LINE_W'(span)) begin
                     q_cmd.op         = OP_SEED;
                     q_cmd.seed_index = seed_idx;
                     q_cmd.seed_start = START_W'(start);
                  end
               end
            end
            MODE_EOL: begin
               line_off_in = '0;
            end
            MODE_READ: begin
               q_cmd.op         = OP_READ;
               q_cmd.status     = ST_READ;
               q_cmd.seed_index = req_payload.bucket;
               q_cmd.slot       = req_payload.slot;
            end
            default: begin
               q_cmd.status = ST_NO_SEED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_off_ff <= '0;
         halted_ff   <= 1'b0;
      end else if (accept) begin
         line_off_ff <= line_off_in;
         halted_ff   <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && shift) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule
`default_nettype wire

@@ design/ssib_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// short command queue between front and back end
// depends on ssib_pkg
module ssib_queue import ssib_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full     = fill_ff == CNT_QW'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ design/ssib_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// back end: bucket count and offset memories, read-modify-write of one command
// at a time and the result register; depends on ssib_pkg
module ssib_back import ssib_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   output logic                  q_pop,
   input  wire cmd_type          q_cmd,
   input  wire logic [CAP_W-1:0] capacity,
   output logic                  clearing,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_payload
);

   localparam int OFF_ADDR_W = IDX_W + SLOT_ADDR_W;
   localparam int OFF_DEPTH  = NUM_BUCKETS * BUCKET_SLOTS;

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   cmd_type            cmd_ff;
   rsp_type            rsp_ff, rsp_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [CNT_W-1:0]   cnt_mem [NUM_BUCKETS];
   logic [START_W-1:0] off_mem [OFF_DEPTH];
   logic [CNT_W-1:0]   cnt_rd_ff;
   logic [START_W-1:0] off_rd_ff;

   logic                  cnt_we, off_we, exec;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [CNT_W-1:0]      cnt_wdata;
   logic [OFF_ADDR_W-1:0] off_waddr;
   logic                  room;

   assign room        = cnt_rd_ff < CNT_W'(capacity);
   assign rsp_payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         BK_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in = BK_RESP;
         end
         BK_RESP: begin
            if (rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      clearing  = 1'b0;
      q_pop     = 1'b0;
      rsp_valid = 1'b0;
      exec      = 1'b0;
      case (state_ff)
         BK_CLEAR: clearing  = 1'b1;
         BK_IDLE:  q_pop     = !q_empty;
         BK_EXEC:  exec      = 1'b1;
         BK_RESP:  rsp_valid = 1'b1;
         default:  q_pop     = 1'b0;
      endcase
   end

   // command execution
   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = cmd_ff.status;
      total_in            = total_ff;
      cnt_we              = clearing;
      cnt_waddr           = clr_ff;
      cnt_wdata           = '0;
      off_we              = 1'b0;
      off_waddr           = {cmd_ff.seed_index, cnt_rd_ff[SLOT_ADDR_W-1:0]};
      case (cmd_ff.op)
         OP_SEED: begin
            rsp_in.seed_index  = cmd_ff.seed_index;
            rsp_in.seed_start  = cmd_ff.seed_start;
            rsp_in.entry_count = cnt_rd_ff;
            rsp_in.status      = ST_DROPPED;
            if (room) begin
               rsp_in.status      = ST_STORED;
               rsp_in.entry_count = cnt_rd_ff + 1'b1;
               off_we             = exec;
               if (exec) begin
                  cnt_we    = 1'b1;
                  cnt_waddr = cmd_ff.seed_index;
                  cnt_wdata = cnt_rd_ff + 1'b1;
               end
               if (total_ff != '1) begin
                  total_in = total_ff + 1'b1;
               end
            end
         end
         OP_READ: begin
            rsp_in.seed_index  = cmd_ff.seed_index;
            rsp_in.entry_count = cnt_rd_ff;
            if (CNT_W'(cmd_ff.slot) < cnt_rd_ff) begin
               rsp_in.read_position = off_rd_ff;
            end
         end
         default: begin
            rsp_in.status = cmd_ff.status;
         end
      endcase
      rsp_in.total_stored = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (exec) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // bucket counts
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (q_pop) begin
         cnt_rd_ff <= cnt_mem[q_cmd.seed_index];
      end
   end

   // bucket offsets
   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_waddr] <= cmd_ff.seed_start;
      end
      if (q_pop) begin
         off_rd_ff <= off_mem[{q_cmd.seed_index, q_cmd.slot[SLOT_ADDR_W-1:0]}];
      end
   end

endmodule
`default_nettype wire

@@ design/spaced_seed_index_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Spaced-seed index builder. Each transaction on req_ is a DNA character, an end of
// line or a bucket read, and gives exactly one transaction on rsp_. After reset all
// 4096 entries of the bucket count memory are cleared, during which req_ready stays low;
// configuration writes are taken at any time. The front end accepts one transaction
// per cycle, while the queue is not full, into a two-entry queue; the back end does the
// count/offset memory read-modify-write for one transaction at a time (memory read,
// update, result) and holds each result until rsp_ready before it pops the next one.
// Depends on ssib_pkg, ssib_front, ssib_queue and ssib_back.
module spaced_seed_index_builder import ssib_pkg::*; #(
   parameter int MAX_STRIDE   = MAX_STRIDE_DEF,
   parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int STRIDE_W = $clog2(MAX_STRIDE + 1);

   logic [SEED_LEN_W-1:0]   seed_len_ff;
   logic [STRIDE_REG_W-1:0] stride_ff;
   logic [CAP_W-1:0]        cap_ff;
   logic [SEED_LEN_W-1:0]   seed_len_eff;
   logic [STRIDE_W-1:0]     stride_eff;
   logic [CAP_W-1:0]        cap_eff;
   logic                    csr_write;
   logic                    q_push, q_pop, q_full, q_empty, clearing;
   cmd_type                 push_cmd, pop_cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_len_ff <= SEED_LEN_RESET;
         stride_ff   <= STRIDE_RESET;
         cap_ff      <= CAP_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_SEED_LENGTH:     seed_len_ff <= pwdata[SEED_LEN_W-1:0];
            REG_STRIDE:          stride_ff   <= pwdata[STRIDE_REG_W-1:0];
            REG_BUCKET_CAPACITY: cap_ff      <= pwdata[CAP_W-1:0];
            default:             seed_len_ff <= seed_len_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SEED_LENGTH:     prdata = CSR_DATA_W'(seed_len_ff);
         REG_STRIDE:          prdata = CSR_DATA_W'(stride_ff);
         REG_BUCKET_CAPACITY: prdata = CSR_DATA_W'(cap_ff);
         default:             prdata = '0;
      endcase
   end

   // saturate registers into their legal ranges
   always_comb begin
      if (seed_len_ff == '0) begin
         seed_len_eff = SEED_LEN_W'(1);
      end else if (int'(seed_len_ff) > MAX_SEED_LEN) begin
         seed_len_eff = SEED_LEN_W'(MAX_SEED_LEN);
      end else begin
         seed_len_eff = seed_len_ff;
      end
      if (stride_ff == '0) begin
         stride_eff = STRIDE_W'(1);
      end else if (int'(stride_ff) > MAX_STRIDE) begin
         stride_eff = STRIDE_W'(MAX_STRIDE);
      end else begin
         stride_eff = STRIDE_W'(stride_ff);
      end
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (int'(cap_ff) > BUCKET_SLOTS) begin
         cap_eff = CAP_W'(BUCKET_SLOTS);
      end else begin
         cap_eff = cap_ff;
      end
   end

   ssib_front #(
      .MAX_STRIDE   (MAX_STRIDE),
      .MAX_LINE_LEN (MAX_LINE_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .seed_len    (seed_len_eff),
      .stride      (stride_eff),
      .q_full      (q_full),
      .clearing    (clearing),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   ssib_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_cmd  (pop_cmd)
   );

   ssib_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_cmd       (pop_cmd),
      .capacity    (cap_eff),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.entry_count <= CNT_W'(BUCKET_SLOTS))
      else $error("entry count beyond bucket slots");

   a_stored_in_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_STORED) |->
         (rsp_payload.entry_count != '0 && rsp_payload.entry_count <= cap_eff))
      else $error("stored seed with bad entry count");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_push && !q_pop)
      else $error("queue traffic during clearing pass");
`endif

endmodule
`default_nettype wire
